// ===== rtl/ulist_pkg.sv =====
// types and codes shared by the unsorted list table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ulist_pkg;

    localparam logic [2:0] FUNC_PUT    = 3'd0;
    localparam logic [2:0] FUNC_SEARCH = 3'd1;
    localparam logic [2:0] FUNC_DELETE = 3'd2;
    localparam logic [2:0] FUNC_NEXT   = 3'd3;
    localparam logic [2:0] FUNC_RESET  = 3'd4;
    localparam logic [2:0] FUNC_CLEAR  = 3'd5;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_MISS = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [6:0]  entry_count;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ulist_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ulist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/unsorted_list_table_core.sv =====
// unsorted list table with iteration cursor, top level
// depends on ulist_pkg and ulist_ram
`timescale 1ns / 1ps
`default_nettype none

// Bounded unsorted list of values with an iteration cursor, one transaction
// at a time. The values sit in a single ram in reverse order (the head is the
// highest filled address), so a put is one write at the fill point. Put,
// reset cursor, clear and unused codes pass from an execute state to the
// result; next adds a ram read state in between. Search scans from the head
// one entry per cycle. Delete scans to the first match and then moves every
// later-stored entry down one place, one per cycle; a miss scans the whole
// list. Scans and moves run through the single read port of the entry ram.
// A new request is taken while the previous result still waits in the
// output register.

module unsorted_list_table_core
    import ulist_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_NEXT  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [2:0]             op_reg, op_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [CW-1:0]          cursor_reg, cursor_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [VALUE_WIDTH-1:0] res_value_reg, res_value_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    logic [VALUE_WIDTH+31:0] key_ext;
    logic [VALUE_WIDTH-1:0]  key_in;
    logic [VALUE_WIDTH+31:0] val_ext;
    logic [CW+6:0]           fill_ext;
    logic [CW-1:0]           fill_m1;
    logic [CW-1:0]           next_phys;
    logic [CW:0]             cur_sum;
    logic [AW-1:0]           addr_p1;
    logic                    out_free;
    logic                    accept;

    assign key_ext   = {{VALUE_WIDTH{1'b0}}, req.key};
    assign key_in    = key_ext[VALUE_WIDTH-1:0];
    assign val_ext   = {32'b0, res_value_reg};
    assign fill_ext  = {7'b0, fill_reg};
    assign fill_m1   = fill_reg - CW'(1);
    assign next_phys = fill_m1 - cursor_reg;
    // logical position of a match is fill - 1 - addr, cursor lies past it when this reaches fill
    assign cur_sum   = {1'b0, cursor_reg} + {{(CW + 1 - AW){1'b0}}, addr_reg};
    assign addr_p1   = addr_reg + AW'(1);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    ulist_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        fill_next       = fill_reg;
        cursor_next     = cursor_reg;
        addr_next       = addr_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        ram_we          = 1'b0;
        ram_waddr       = fill_reg[AW-1:0];
        ram_wdata       = key_reg;
        ram_raddr       = fill_m1[AW-1:0];

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.func;
                    key_next   = key_in;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = STATUS_OK;
                res_value_next  = '0;
                state_next      = S_DONE;
                unique case (op_reg) inside
                    FUNC_PUT:
                    begin
                        if (fill_reg >= CW'(CAPACITY))
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            fill_next = fill_reg + CW'(1);
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg + CW'(1);
                            end
                        end
                    end
                    FUNC_SEARCH, FUNC_DELETE:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = STATUS_MISS;
                        end
                        else
                        begin
                            // scan starts at the head, the highest filled address
                            addr_next  = fill_m1[AW-1:0];
                            state_next = S_SCAN;
                        end
                    end
                    FUNC_NEXT:
                    begin
                        if (cursor_reg < fill_reg)
                        begin
                            ram_raddr  = next_phys[AW-1:0];
                            state_next = S_NEXT;
                        end
                        else
                        begin
                            res_status_next = STATUS_MISS;
                        end
                    end
                    FUNC_RESET:
                    begin
                        cursor_next = '0;
                    end
                    FUNC_CLEAR:
                    begin
                        fill_next   = '0;
                        cursor_next = '0;
                    end
                    default:
                    begin
                        res_status_next = STATUS_MISS;
                    end
                endcase
            end
            S_NEXT:
            begin
                res_value_next = ram_rdata;
                cursor_next    = cursor_reg + CW'(1);
                state_next     = S_DONE;
            end
            S_SCAN:
            begin
                // ram_rdata holds the entry at addr_reg, the next read is issued alongside
                ram_raddr = addr_reg - AW'(1);
                if (ram_rdata == key_reg)
                begin
                    if (op_reg == FUNC_SEARCH)
                    begin
                        res_value_next = key_reg;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        if (cur_sum >= {1'b0, fill_reg})
                        begin
                            cursor_next = cursor_reg - CW'(1);
                        end
                        if (addr_reg == fill_m1[AW-1:0])
                        begin
                            fill_next  = fill_m1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            ram_raddr  = addr_p1;
                            state_next = S_SHIFT;
                        end
                    end
                end
                else if (addr_reg == '0)
                begin
                    res_status_next = STATUS_MISS;
                    state_next      = S_DONE;
                end
                else
                begin
                    addr_next = addr_reg - AW'(1);
                end
            end
            S_SHIFT:
            begin
                // close the gap: entry at addr + 1 moves down to addr
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = ram_rdata;
                ram_raddr = addr_reg + AW'(2);
                addr_next = addr_p1;
                if (addr_p1 == fill_m1[AW-1:0])
                begin
                    fill_next  = fill_m1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = res_status_reg;
                    rsp_next.value_out   = val_ext[31:0];
                    rsp_next.entry_count = fill_ext[6:0];
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            cursor_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cursor_reg    <= cursor_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        rsp_reg        <= rsp_next;
    end

    // cursor never passes the end of the list
    assert property (@(posedge clk) disable iff (!rst_n) cursor_reg <= fill_reg)
        else $error("cursor beyond fill count");

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    // compaction never reads the entry it is writing, bar the unused read on the last move
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |->
            (ram_we && (addr_p1 == fill_m1[AW-1:0] || ram_raddr != ram_waddr)))
        else $error("shift read and write collide");

    // the length moves by one per transaction, or drops to zero on clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |->
            (fill_reg == $past(fill_reg) + CW'(1) || fill_reg == $past(fill_reg) - CW'(1)
             || fill_reg == '0))
        else $error("fill count jumped");

endmodule

`default_nettype wire

// ===== tb/unsorted_list_table_core_tb.sv =====
// self-checking testbench for the unsorted list table with iteration cursor
// depends on ulist_pkg and unsorted_list_table_core; carries its own list predictor
`timescale 1ns / 1ps

module unsorted_list_table_core_tb;
    import ulist_pkg::*;

    localparam int          CAPACITY    = 64;
    localparam int          VALUE_WIDTH = 32;
    localparam logic [31:0] VALUE_MASK  = (VALUE_WIDTH >= 32) ? 32'hFFFF_FFFF
                                                              : ((32'd1 << VALUE_WIDTH) - 32'd1);
    localparam int          ITEM_TARGET = 1800;
    localparam int          HOLD_LEN    = 400;
    localparam int          DRAIN_WAIT  = 2 * CAPACITY + 16;
    localparam logic [2:0]  FUNC_SPARE6 = 3'd6;
    localparam logic [2:0]  FUNC_SPARE7 = 3'd7;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    unsorted_list_table_core #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // predictor state: position 0 is the head
    logic [31:0] list_store [CAPACITY];
    int          list_fill   = 0;
    int          list_cursor = 0;

    req_t        pending_reqs [$];
    rsp_t        expected_rsps [$];
    logic [31:0] put_history [$];
    logic [31:0] key_pool [12];

    int  sent_count     = 0;
    int  checked_count  = 0;
    int  error_count    = 0;
    int  full_refusals  = 0;
    int  match_hits     = 0;
    int  end_of_list    = 0;
    int  gap_left       = 0;
    int  stall_left     = 0;
    int  hold_cycles    = 0;
    int  holds_done     = 0;
    logic hold_on       = 1'b0;

    // every fourth stretch of 150 transactions runs with no idling on either side
    wire quiet = ((sent_count / 150) % 4) == 3;

    function automatic rsp_t list_apply(input req_t r);
        rsp_t        o;
        logic [31:0] v;
        int          hit;
        o   = '0;
        v   = r.key & VALUE_MASK;
        hit = -1;
        o.status = STATUS_OK;
        if (r.func == FUNC_SEARCH || r.func == FUNC_DELETE)
        begin
            for (int i = 0; i < list_fill; i++)
            begin
                if (hit < 0 && list_store[i] == v)
                    hit = i;
            end
        end
        case (r.func)
            FUNC_PUT:
            begin
                if (list_fill >= CAPACITY)
                begin
                    o.status = STATUS_FULL;
                    full_refusals++;
                end
                else
                begin
                    for (int i = list_fill; i > 0; i--)
                        list_store[i] = list_store[i - 1];
                    list_store[0] = v;
                    list_fill++;
                    if (list_cursor != 0)
                        list_cursor++;
                end
            end
            FUNC_SEARCH:
            begin
                if (hit >= 0)
                begin
                    o.value_out = v;
                    match_hits++;
                end
                else
                    o.status = STATUS_MISS;
            end
            FUNC_DELETE:
            begin
                if (hit < 0)
                    o.status = STATUS_MISS;
                else
                begin
                    for (int i = hit; i + 1 < list_fill; i++)
                        list_store[i] = list_store[i + 1];
                    list_fill--;
                    if (list_cursor > hit)
                        list_cursor--;
                    match_hits++;
                end
            end
            FUNC_NEXT:
            begin
                if (list_cursor < list_fill)
                begin
                    o.value_out = list_store[list_cursor];
                    list_cursor++;
                end
                else
                begin
                    o.status = STATUS_MISS;
                    end_of_list++;
                end
            end
            FUNC_RESET:
                list_cursor = 0;
            FUNC_CLEAR:
            begin
                list_fill   = 0;
                list_cursor = 0;
            end
            default:
                o.status = STATUS_MISS;
        endcase
        o.entry_count = list_fill[6:0];
        return o;
    endfunction

    task automatic queue_req(input logic [2:0] func, input logic [31:0] key);
        req_t r;
        r.func = func;
        r.key  = key;
        pending_reqs.push_back(r);
        if (func == FUNC_PUT)
        begin
            put_history.push_back(key);
            if (put_history.size() > CAPACITY)
                void'(put_history.pop_front());
        end
    endtask

    // mostly keys that collide, so search and delete find matches
    function automatic logic [31:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return key_pool[$urandom_range(0, 11)];
        else if (roll < 80 && put_history.size() != 0)
            return put_history[$urandom_range(0, put_history.size() - 1)];
        else
            return $urandom;
    endfunction

    // driver: one transaction offered at a time, gap drawn per item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            gap_left  <= 0;
        end
        else
        begin : drive
            int gap;
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(list_apply(req));
                sent_count <= sent_count + 1;
                gap = quiet ? 0 : $urandom_range(0, 9);
                if (gap == 0 && pending_reqs.size() != 0)
                    req <= pending_reqs.pop_front();
                else
                begin
                    req_valid <= 1'b0;
                    gap_left  <= gap;
                end
            end
            else if (!req_valid)
            begin
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                else if (pending_reqs.size() != 0)
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
            end
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_on     <= 1'b0;
            hold_cycles <= 0;
            holds_done  <= 0;
        end
        else if (!hold_on && holds_done < 2 && sent_count >= 600 * (holds_done + 1))
        begin
            hold_on     <= 1'b1;
            hold_cycles <= 0;
            holds_done  <= holds_done + 1;
        end
        else if (hold_on)
        begin
            if (hold_cycles == HOLD_LEN - 1)
                hold_on <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end
    end

    // monitor: compares each accepted result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin : observe
            rsp_t want;
            int   wait_n;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %p", $time, rsp);
                    error_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    checked_count++;
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t status mismatch: expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                        error_count++;
                    end
                    if (rsp.value_out !== want.value_out)
                    begin
                        $display("%0t value_out mismatch: expected %h actual %h",
                                 $time, want.value_out, rsp.value_out);
                        error_count++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $display("%0t entry_count mismatch: expected %0d actual %0d",
                                 $time, want.entry_count, rsp.entry_count);
                        error_count++;
                    end
                end
                wait_n = quiet ? 0 : $urandom_range(0, 9);
                stall_left <= wait_n;
                rsp_stall  <= hold_on || (wait_n != 0);
            end
            else
            begin
                if (stall_left != 0)
                    stall_left <= stall_left - 1;
                rsp_stall <= hold_on || (stall_left > 1);
            end
        end
    end

    initial
    begin : stimulus
        int seg;
        int n;
        int roll;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'h0000_0001;
        key_pool[4] = 32'h7FFF_FFFF;
        key_pool[5] = 32'hAAAA_AAAA;
        key_pool[6] = 32'h5555_5555;
        for (int i = 7; i < 12; i++)
            key_pool[i] = $urandom;

        // directed opening on an empty list, then the cursor cases
        queue_req(FUNC_NEXT,   32'h0);
        queue_req(FUNC_SEARCH, 32'h0);
        queue_req(FUNC_DELETE, 32'h0);
        queue_req(FUNC_RESET,  32'h0);
        queue_req(FUNC_PUT,    32'h0000_0000);
        queue_req(FUNC_PUT,    32'hFFFF_FFFF);
        queue_req(FUNC_NEXT,   32'h0);
        queue_req(FUNC_PUT,    32'h1234_5678);
        queue_req(FUNC_SEARCH, 32'hFFFF_FFFF);
        queue_req(FUNC_SEARCH, 32'hDEAD_BEEF);
        queue_req(FUNC_DELETE, 32'h0000_0000);
        queue_req(FUNC_DELETE, 32'h1234_5678);
        queue_req(FUNC_NEXT,   32'h0);
        queue_req(FUNC_NEXT,   32'h0);
        queue_req(FUNC_SPARE6, 32'hFFFF_FFFF);
        queue_req(FUNC_SPARE7, 32'h0);
        queue_req(FUNC_PUT,    32'h8000_0000);
        queue_req(FUNC_RESET,  32'h0);
        queue_req(FUNC_NEXT,   32'h0);
        queue_req(FUNC_DELETE, 32'hFFFF_FFFF);
        queue_req(FUNC_CLEAR,  32'h0);
        queue_req(FUNC_NEXT,   32'h0);
        queue_req(FUNC_DELETE, 32'hDEAD_BEEF);

        // first random segment is always a fill run, which can push the list past capacity
        seg = 6;
        while (pending_reqs.size() < ITEM_TARGET)
        begin
            case (seg)
                5, 6:
                begin
                    // fill run: 40 to 72 puts, which can be refused on a full list, then a look around
                    n = $urandom_range(40, 72);
                    for (int i = 0; i < n; i++)
                        queue_req(FUNC_PUT, pick_key());
                    for (int i = 0; i < 4; i++)
                        queue_req(FUNC_SEARCH, pick_key());
                end
                7, 8:
                begin
                    // walk the cursor over the list with the odd delete and put on the way
                    queue_req(FUNC_RESET, $urandom);
                    n = $urandom_range(10, 70);
                    for (int i = 0; i < n; i++)
                    begin
                        roll = $urandom_range(0, 19);
                        if (roll == 0)
                            queue_req(FUNC_DELETE, pick_key());
                        else if (roll == 1)
                            queue_req(FUNC_PUT, pick_key());
                        else
                            queue_req(FUNC_NEXT, $urandom);
                    end
                end
                9:
                begin
                    // drain: mostly deletes of picked keys, with the odd next
                    n = $urandom_range(10, 30);
                    for (int i = 0; i < n; i++)
                        queue_req($urandom_range(0, 3) == 0 ? FUNC_NEXT : FUNC_DELETE,
                                  pick_key());
                end
                default:
                begin
                    for (int i = 0; i < 30; i++)
                    begin
                        roll = $urandom_range(0, 99);
                        if (roll < 35)
                            queue_req(FUNC_PUT, pick_key());
                        else if (roll < 50)
                            queue_req(FUNC_SEARCH, pick_key());
                        else if (roll < 65)
                            queue_req(FUNC_DELETE, pick_key());
                        else if (roll < 80)
                            queue_req(FUNC_NEXT, $urandom);
                        else if (roll < 88)
                            queue_req(FUNC_RESET, $urandom);
                        else if (roll < 92)
                            queue_req(FUNC_CLEAR, $urandom);
                        else if (roll < 96)
                            queue_req($urandom_range(0, 1) ? FUNC_SPARE6 : FUNC_SPARE7,
                                      $urandom);
                        else
                            queue_req(FUNC_PUT, $urandom);
                    end
                end
            endcase
            seg = $urandom_range(0, 9);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("checked %0d results over %0d requests, %0d receiver hold-offs",
                 checked_count, sent_count, holds_done);
        $display("%0d puts refused on a full list, %0d search/delete matches, %0d nexts at end",
                 full_refusals, match_hits, end_of_list);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("%0t timeout with %0d results outstanding", $time, expected_rsps.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ulist_pkg.sv
rtl/ulist_ram.sv
rtl/unsorted_list_table_core.sv
tb/unsorted_list_table_core_tb.sv
